// ===== hw/rtl/rtufr_pkg.sv =====
// ----------------------------------------------------------------------------
// RTU frame receiver package
// Shared types, codes and the CRC-16 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package rtufr_pkg;

  // Default frame buffer depth in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 64;

  // CRC-16, reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes
  localparam logic [7:0] FN_SINGLE_FIRST = 8'h01;
  localparam logic [7:0] FN_SINGLE_LAST  = 8'h06;
  localparam logic [7:0] FN_MULTI_COILS  = 8'h0F;
  localparam logic [7:0] FN_MULTI_REGS   = 8'h10;

  // Fixed frame lengths and positions
  localparam int unsigned HDR_BYTES      = 7;  // address .. byte count
  localparam int unsigned MIN_CHECK_LEN  = 5;
  localparam int unsigned SINGLE_LEN     = 8;
  localparam int unsigned MULTI_OVERHEAD = 9;
  localparam int unsigned PAYLOAD_START  = 7;
  localparam int unsigned CRC_BYTES      = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_ADDR = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;

  localparam logic [15:0] TIMEOUT_RST = 16'd10;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ADDR = 2'd1,
    ST_BAD_FUNC = 2'd2,
    ST_BAD_CRC  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EMIT
  } state_e;

  // Header bytes and CRC state from the intake
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] fn;
    logic [7:0] fa_hi;
    logic [7:0] fa_lo;
    logic [7:0] qv_hi;
    logic [7:0] qv_lo;
    logic [7:0] count;
    logic       crc_zero;
  } frame_info_t;

  // Control from the sequencer to the intake
  typedef struct packed {
    logic clear;
    logic rd_en;
  } intake_ctrl_t;

  // One byte of CRC-16 update, LSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rtu_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// RTU frame receiver
// Collects request bytes, checks address, function, length and CRC, and
// emits a header result followed by the data bytes of multiple-write frames.
// ----------------------------------------------------------------------------
// A tick, or a byte that is not stored, leaves the block ready for input;
// a stored byte is accepted and then checked in the S_CHECK state, during
// which no input is taken. A finished frame emits its header from the check
// state and then each payload byte through a memory read (S_READ) and an
// output load (S_EMIT), held while the output stalls. The input is taken
// again as soon as the last result sits in the output register. The buffer
// needs no clearing pass after reset.
module rtu_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = rtufr_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] operation (0 tick, 1 byte)
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // status, function_code, first_address,
                                        // quantity_or_value, payload_byte, 0 fill
  output logic        m_axis_tuser_o,   // [0] payload_valid
  output logic        m_axis_tlast_o
);
  import rtufr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  state_e        state_q, state_d;
  logic [7:0]    own_addr_q;
  logic [15:0]   timeout_q;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] fill;
  logic [7:0]    rd_data;
  logic          stored;
  frame_info_t   info;
  intake_ctrl_t  ctrl;
  logic          in_acc, out_free;

  // Output register
  logic          ovalid_q;
  status_e       ostatus_q, res_status;
  logic [7:0]    ofn_q, res_fn;
  logic [15:0]   ofa_q, res_fa;
  logic [15:0]   oqv_q, res_qv;
  logic [7:0]    opb_q, res_pb;
  logic          opv_q, res_pv;
  logic          olast_q, res_last;
  logic          load;

  // Frame check terms
  logic [8:0]    fill9, need9;
  logic          fn_single, fn_multi, addr_bad, complete;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !ovalid_q || m_axis_tready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_OWN_ADDR: own_addr_q <= cfg_data_i[7:0];
        REG_TIMEOUT:  timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rtufr_intake #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .AW          (AW)
  ) u_intake (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (in_acc && !s_axis_tuser_i),
    .byte_i   (in_acc && s_axis_tuser_i),
    .rx_byte_i(s_axis_tdata_i),
    .timeout_i(timeout_q),
    .ctrl_i   (ctrl),
    .rd_addr_i(idx_q),
    .rd_data_o(rd_data),
    .stored_o (stored),
    .fill_o   (fill),
    .info_o   (info)
  );

  // Frame check terms
  always_comb begin
    fill9     = 9'(fill);
    fn_single = (info.fn >= FN_SINGLE_FIRST) && (info.fn <= FN_SINGLE_LAST);
    fn_multi  = (info.fn == FN_MULTI_COILS) || (info.fn == FN_MULTI_REGS);
    addr_bad  = (info.addr != own_addr_q) || (own_addr_q == 8'h00);
    need9     = fn_single ? 9'(SINGLE_LEN) : ({1'b0, info.count} + 9'(MULTI_OVERHEAD));
    complete  = (fill9 == need9);
  end

  // Sequencer: next state, result selection, intake control
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    load       = 1'b0;
    ctrl       = '0;
    res_status = ST_OK;
    res_fn     = '0;
    res_fa     = '0;
    res_qv     = '0;
    res_pb     = '0;
    res_pv     = 1'b0;
    res_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (stored) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_fn = info.fn;
        if (fill9 < 9'(MIN_CHECK_LEN)) begin
          state_d = S_IDLE;
        end else if (addr_bad || !(fn_single || fn_multi)) begin
          res_status = addr_bad ? ST_BAD_ADDR : ST_BAD_FUNC;
          if (out_free) begin
            load       = 1'b1;
            ctrl.clear = 1'b1;
            state_d    = S_IDLE;
          end
        end else if ((fn_multi && fill9 < 9'(HDR_BYTES)) || !complete) begin
          state_d = S_IDLE;
        end else begin
          res_fa     = {info.fa_hi, info.fa_lo};
          res_qv     = {info.qv_hi, info.qv_lo};
          res_status = info.crc_zero ? ST_OK : ST_BAD_CRC;
          res_last   = !info.crc_zero || fn_single || (info.count == 8'h00);
          if (out_free) begin
            load = 1'b1;
            if (res_last) begin
              ctrl.clear = 1'b1;
              state_d    = S_IDLE;
            end else begin
              idx_d   = AW'(PAYLOAD_START);
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        ctrl.rd_en = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        res_pb   = rd_data;
        res_pv   = 1'b1;
        res_last = (({1'b0, idx_q} + (AW+1)'(CRC_BYTES + 1)) == {1'b0, fill});
        if (out_free) begin
          load = 1'b1;
          if (res_last) begin
            ctrl.clear = 1'b1;
            state_d    = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      ostatus_q <= res_status;
      ofn_q     <= res_fn;
      ofa_q     <= res_fa;
      oqv_q     <= res_qv;
      opb_q     <= res_pb;
      opv_q     <= res_pv;
      olast_q   <= res_last;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {6'b0, opb_q, oqv_q, ofa_q, ofn_q, ostatus_q};
  assign m_axis_tuser_o  = opv_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

// ===== hw/rtl/rtufr_intake.sv =====
// ----------------------------------------------------------------------------
// RTU frame intake
// Silence counter, frame buffer memory, fill count, running CRC and
// header byte capture.
// ----------------------------------------------------------------------------
module rtufr_intake #(
  parameter int unsigned BUFFER_BYTES = rtufr_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned AW           = $clog2(BUFFER_BYTES)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   byte_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [15:0]            timeout_i,
  input  rtufr_pkg::intake_ctrl_t ctrl_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic [7:0]             rd_data_o,
  output logic                   stored_o,
  output logic [AW-1:0]          fill_o,
  output rtufr_pkg::frame_info_t info_o
);
  import rtufr_pkg::*;

  localparam logic [AW-1:0] FILL_MAX = AW'(BUFFER_BYTES - 1);
  localparam logic [AW-1:0] HDR_LEN  = AW'(HDR_BYTES);

  logic [7:0]    mem_q [BUFFER_BYTES];
  logic [7:0]    rd_data_q;
  logic [7:0]    hdr_q [HDR_BYTES];
  logic [AW-1:0] fill_q, fill_d, base_fill;
  logic [15:0]   crc_q, crc_d, base_crc;
  logic [15:0]   silence_q, silence_d;
  logic          timed_out;
  logic          store;

  // Restart on a byte after too long a silence, then store if room
  always_comb begin
    timed_out = silence_q > timeout_i;
    base_fill = timed_out ? '0 : fill_q;
    base_crc  = timed_out ? CRC_INIT : crc_q;
    store     = byte_i && (base_fill < FILL_MAX);
    fill_d    = fill_q;
    crc_d     = crc_q;
    silence_d = silence_q;
    if (ctrl_i.clear) begin
      fill_d = '0;
      crc_d  = CRC_INIT;
    end else if (byte_i) begin
      fill_d = store ? base_fill + AW'(1) : base_fill;
      crc_d  = store ? crc_byte(base_crc, rx_byte_i) : base_crc;
    end
    if (byte_i) begin
      silence_d = '0;
    end else if (tick_i && silence_q != 16'hFFFF) begin
      silence_d = silence_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      crc_q     <= CRC_INIT;
      silence_q <= '0;
    end else begin
      fill_q    <= fill_d;
      crc_q     <= crc_d;
      silence_q <= silence_d;
    end
  end

  // Frame buffer: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[base_fill] <= rx_byte_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Header bytes kept beside the buffer for the checks
  always_ff @(posedge clk_i) begin
    if (store && base_fill < HDR_LEN) begin
      hdr_q[base_fill[2:0]] <= rx_byte_i;
    end
  end

  assign rd_data_o = rd_data_q;
  assign stored_o  = store;
  assign fill_o    = fill_q;

  assign info_o.addr     = hdr_q[0];
  assign info_o.fn       = hdr_q[1];
  assign info_o.fa_hi    = hdr_q[2];
  assign info_o.fa_lo    = hdr_q[3];
  assign info_o.qv_hi    = hdr_q[4];
  assign info_o.qv_lo    = hdr_q[5];
  assign info_o.count    = hdr_q[6];
  assign info_o.crc_zero = (crc_q == 16'h0000);

endmodule
